### design/bol_pkg.sv
// types and constants shared by the ordered list and its storage cells
// no dependencies
`default_nettype none

package bol_pkg;

  // widest cell index and element count the cell row supports
  localparam int unsigned IDX_W = 8;
  localparam int unsigned LEN_W = 9;

  typedef enum logic [2:0] {
    MODE_CLEAR      = 3'd0,
    MODE_PUSH_FRONT = 3'd1,
    MODE_PUSH_BACK  = 3'd2,
    MODE_INSERT_AT  = 3'd3,
    MODE_POP_FRONT  = 3'd4,
    MODE_POP_BACK   = 3'd5,
    MODE_SEARCH     = 3'd6,
    MODE_READ_AT    = 3'd7
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_POS   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_REM  = 2'd2
  } cell_op_e;

  typedef enum logic [1:0] {
    S_IDLE    = 2'd0,
    S_COLLECT = 2'd1,
    S_OUT     = 2'd2
  } state_e;

  typedef struct packed {
    mode_e              mode;
    logic signed [31:0] value;
    logic [4:0]         position;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic               found;
    logic signed [31:0] read_value;
    logic [4:0]         count;
  } rsp_t;

  // broadcast to every cell of the row
  typedef struct packed {
    cell_op_e           op;
    logic [IDX_W-1:0]   idx;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_idx;
    logic               srch_en;
    logic [LEN_W-1:0]   len;
    logic signed [31:0] value;
  } cell_cmd_t;

endpackage

`default_nettype wire

### design/bounded_ordered_list.sv
// bounded ordered list of signed 32-bit values kept in a row of bol_cell
// cells, with request decode, element count and response register; uses bol_pkg
//
//   port        dir  handshake               payload
//   in request  in   in_valid_i/in_stall_o   in_req_i  (req_t)
//   out result  out  out_valid_o/out_stall_i out_rsp_o (rsp_t)
//
// per request: cells shift and compare on the accept edge,
// hit and read data of all cells are merged in the collect state, the result shows in the out state
// in_stall_o is high from acceptance until the result has been taken
// reset empties the list; cell contents are not cleared
// a stalled result holds, and no new request is taken meanwhile
`default_nettype none

module bounded_ordered_list
  import bol_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_stall_o,
  input  wire req_t  in_req_i,
  output logic       out_valid_o,
  input  wire        out_stall_i,
  output rsp_t       out_rsp_o
);

  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW + 1 > 5) ? CW + 1 : 5;

  state_e state_q, state_d;
  logic [CW-1:0] len_q, len_d;
  status_e status_q, status_d;
  rsp_t rsp_q, rsp_d;
  cell_cmd_t cmd;
  logic in_fire;

  logic [CMPW-1:0] len_e, pos_e, len_nx;

  logic signed [31:0] cell_data [DEPTH];
  logic               cell_hit  [DEPTH];
  logic signed [31:0] cell_rd   [DEPTH];

  assign in_fire = in_valid_i && !in_stall_o;
  assign len_e   = CMPW'(len_q);
  assign pos_e   = CMPW'(in_req_i.position);

  // request decode
  always_comb begin
    status_d    = ST_OK;
    len_nx      = len_e;
    cmd.op      = CELL_HOLD;
    cmd.idx     = '0;
    cmd.rd_en   = 1'b0;
    cmd.rd_idx  = '0;
    cmd.srch_en = 1'b0;
    cmd.len     = LEN_W'(len_q);
    cmd.value   = in_req_i.value;
    unique case (in_req_i.mode)
      MODE_CLEAR: len_nx = '0;
      MODE_PUSH_FRONT: begin
        if (len_e == CMPW'(DEPTH)) begin
          status_d = ST_FULL;
        end else begin
          cmd.op = CELL_INS;
          len_nx = len_e + 1'b1;
        end
      end
      MODE_PUSH_BACK: begin
        if (len_e == CMPW'(DEPTH)) begin
          status_d = ST_FULL;
        end else begin
          cmd.op  = CELL_INS;
          cmd.idx = IDX_W'(len_e);
          len_nx  = len_e + 1'b1;
        end
      end
      MODE_INSERT_AT: begin
        if (len_e == CMPW'(DEPTH)) begin
          status_d = ST_FULL;
        end else if (pos_e == '0 || pos_e > len_e + 1'b1) begin
          status_d = ST_POS;
        end else begin
          cmd.op  = CELL_INS;
          cmd.idx = IDX_W'(pos_e - 1'b1);
          len_nx  = len_e + 1'b1;
        end
      end
      MODE_POP_FRONT: begin
        if (len_e == '0) begin
          status_d = ST_EMPTY;
        end else begin
          cmd.op = CELL_REM;
          len_nx = len_e - 1'b1;
        end
      end
      MODE_POP_BACK: begin
        if (len_e == '0) begin
          status_d = ST_EMPTY;
        end else begin
          len_nx = len_e - 1'b1;
        end
      end
      MODE_SEARCH: begin
        if (len_e == '0) begin
          status_d = ST_EMPTY;
        end else begin
          cmd.srch_en = 1'b1;
        end
      end
      MODE_READ_AT: begin
        if (len_e == '0) begin
          status_d = ST_EMPTY;
        end else if (pos_e == '0 || pos_e > len_e) begin
          status_d = ST_POS;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_idx = IDX_W'(pos_e - 1'b1);
        end
      end
      default: status_d = ST_OK;
    endcase
    if (!in_fire) begin
      cmd.op      = CELL_HOLD;
      cmd.rd_en   = 1'b0;
      cmd.srch_en = 1'b0;
    end
  end

  assign len_d = in_fire ? CW'(len_nx) : len_q;

  // cell row
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic signed [31:0] left_w, right_w;
    if (k == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign right_w = cell_data[k];
    end else begin : g_mid_r
      assign right_w = cell_data[k+1];
    end
    bol_cell #(.IDX(k)) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (cell_data[k]),
      .hit_o   (cell_hit[k]),
      .rd_o    (cell_rd[k])
    );
  end

  // merge of registered cell results
  always_comb begin
    logic               any_hit;
    logic signed [31:0] rd_acc;
    any_hit = 1'b0;
    rd_acc  = '0;
    for (int i = 0; i < DEPTH; i++) begin
      any_hit = any_hit | cell_hit[i];
      rd_acc  = rd_acc | cell_rd[i];
    end
    rsp_d            = rsp_q;
    rsp_d.status     = status_q;
    rsp_d.found      = any_hit;
    rsp_d.read_value = rd_acc;
    rsp_d.count      = len_e[4:0];
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:    if (in_fire) state_d = S_COLLECT;
      S_COLLECT: state_d = S_OUT;
      S_OUT:     if (!out_stall_i) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_stall_o  = (state_q != S_IDLE);
    out_valid_o = (state_q == S_OUT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      len_q   <= '0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      status_q <= status_d;
    end
    if (state_q == S_COLLECT) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_rsp_o = rsp_q;

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= CW'(DEPTH))
    else $error("element count above depth");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_req_i.mode == MODE_CLEAR |=> len_q == '0)
    else $error("clear left elements behind");

  a_accept_collect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == S_COLLECT && in_stall_o)
    else $error("request accepted without collect cycle");

  a_fail_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status != ST_OK |->
      out_rsp_o.found == 1'b0 && out_rsp_o.read_value == '0)
    else $error("failed request carries data");

  a_count_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_rsp_o.count == len_e[4:0])
    else $error("reported count differs from list length");

endmodule

`default_nettype wire

### design/bol_cell.sv
// one storage cell of the ordered list row: holds one element, shifts to or
// from its neighbours and compares against the broadcast request; uses bol_pkg
`default_nettype none

module bol_cell
  import bol_pkg::*;
#(
  parameter int unsigned IDX = 0
) (
  input  wire                      clk_i,
  input  wire cell_cmd_t           cmd_i,
  input  wire logic signed [31:0]  left_i,
  input  wire logic signed [31:0]  right_i,
  output logic signed [31:0]       data_o,
  output logic                     hit_o,
  output logic signed [31:0]       rd_o
);

  localparam logic [LEN_W-1:0] K = LEN_W'(IDX);

  logic signed [31:0] data_q, data_d;
  logic               hit_q, hit_d;
  logic signed [31:0] rd_q, rd_d;
  logic [LEN_W-1:0]   idx_ext, rd_idx_ext;

  assign idx_ext    = LEN_W'(cmd_i.idx);
  assign rd_idx_ext = LEN_W'(cmd_i.rd_idx);

  always_comb begin
    data_d = data_q;
    unique case (cmd_i.op)
      CELL_INS: begin
        if (K > idx_ext) begin
          data_d = left_i;
        end else if (K == idx_ext) begin
          data_d = cmd_i.value;
        end
      end
      CELL_REM: begin
        if (K >= idx_ext) begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
    hit_d = cmd_i.srch_en && (K < cmd_i.len) && (data_q == cmd_i.value);
    rd_d  = (cmd_i.rd_en && (K == rd_idx_ext)) ? data_q : '0;
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    hit_q  <= hit_d;
    rd_q   <= rd_d;
  end

  assign data_o = data_q;
  assign hit_o  = hit_q;
  assign rd_o   = rd_q;

endmodule

`default_nettype wire
